// ===== rtl/core/in_order_op_receiver_macros.svh =====
// Assertion macros used by the receiver RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef IN_ORDER_OP_RECEIVER_MACROS_SVH
`define IN_ORDER_OP_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define IOOR_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("ioor check failed");

// Check that a trigger is followed by a condition in the next cycle.
`define IOOR_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("ioor sequence check failed");

`else

`define IOOR_ASSERT(lbl, cond)
`define IOOR_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ===== rtl/core/ioor_pkg.sv =====
// Types and constants of the in-order operation receiver.
`timescale 1ns / 1ps

package ioor_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] MAX_OP_VALUE = 32'd99999999;
  localparam logic [7:0]  OPK_ADD      = 8'd1;
  localparam logic [7:0]  OPK_REMOVE   = 8'd2;
  localparam logic        CMD_BEACON   = 1'b0;
  localparam logic [15:0] SENDER_ANY   = 16'd0;
  localparam logic [15:0] TX_SEQ_RESET = 16'd1;

  typedef enum logic [1:0] {
    REG_OWN_ID         = 2'd0,
    REG_ALLOWED_SENDER = 2'd1,
    REG_STREAM_NUMBER  = 2'd2,
    REG_START_OP       = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REPLY_REQUEST = 2'd0,
    REPLY_ACK     = 2'd1,
    REPLY_NACK    = 2'd2
  } reply_kind_e;

  typedef enum logic [2:0] {
    NACK_RECEIVER = 3'd0,
    NACK_STREAM   = 3'd1,
    NACK_INVALID  = 3'd2,
    NACK_GAP      = 3'd3,
    NACK_APPLY    = 3'd4
  } nack_code_e;

  typedef struct packed {
    logic        cmd;
    logic        frame_ok;
    logic [15:0] src_node;
    logic [15:0] dest_id;
    logic [31:0] frame_stream;
    logic [31:0] op_number;
    logic [7:0]  op_kind;
    logic [31:0] op_value;
    logic        apply_ok;
  } frame_t;

  typedef struct packed {
    logic [15:0] own_id;
    logic [15:0] allowed_sender;
    logic [31:0] stream_number;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic        apply;
    reply_kind_e kind;
    logic [31:0] op;
    nack_code_e  code;
  } decision_t;

  typedef struct packed {
    reply_kind_e kind;
    logic [15:0] dest;
    logic [15:0] seq;
    logic [31:0] stream;
    logic [31:0] op;
    nack_code_e  code;
  } reply_t;

endpackage

// ===== rtl/core/ioor_frame_if.sv =====
// Handshake channel carrying one decoded frame.
`timescale 1ns / 1ps

interface ioor_frame_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        frame_ok;
  logic [15:0] src_node;
  logic [15:0] dest_id;
  logic [31:0] frame_stream;
  logic [31:0] op_number;
  logic [7:0]  op_kind;
  logic [31:0] op_value;
  logic        apply_ok;

  modport source (
    output valid, cmd, frame_ok, src_node, dest_id, frame_stream,
           op_number, op_kind, op_value, apply_ok,
    input  ready
  );

  modport sink (
    input  valid, cmd, frame_ok, src_node, dest_id, frame_stream,
           op_number, op_kind, op_value, apply_ok,
    output ready
  );
endinterface

// ===== rtl/core/ioor_reply_if.sv =====
// Handshake channel carrying one reply item.
`timescale 1ns / 1ps

interface ioor_reply_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [15:0] reply_dest;
  logic [15:0] reply_seq;
  logic [31:0] reply_stream;
  logic [31:0] reply_op;
  logic [2:0]  nack_code;

  modport source (
    output valid, reply_kind, reply_dest, reply_seq, reply_stream, reply_op, nack_code,
    input  ready
  );

  modport sink (
    input  valid, reply_kind, reply_dest, reply_seq, reply_stream, reply_op, nack_code,
    output ready
  );
endinterface

// ===== rtl/core/ioor_decide.sv =====
// Frame classification: decides whether a frame is answered and how.
`timescale 1ns / 1ps

module ioor_decide (
  input  ioor_pkg::frame_t    frame_i,
  input  ioor_pkg::cfg_t      cfg_i,
  input  logic [31:0]         last_applied_i,
  output ioor_pkg::decision_t dec_o
);
  import ioor_pkg::*;

  logic [31:0] next_op;
  logic        sender_bad;
  logic        stream_bad;
  logic        op_invalid;
  logic        op_old;

  assign next_op    = last_applied_i + 32'd1;
  assign sender_bad = (cfg_i.allowed_sender != SENDER_ANY) &&
                      (frame_i.src_node != cfg_i.allowed_sender);
  assign stream_bad = frame_i.frame_stream != cfg_i.stream_number;
  assign op_invalid = (frame_i.op_value > MAX_OP_VALUE) ||
                      ((frame_i.op_kind != OPK_ADD) && (frame_i.op_kind != OPK_REMOVE));
  assign op_old     = frame_i.op_number <= last_applied_i;

  always_comb begin
    dec_o.emit  = 1'b0;
    dec_o.apply = 1'b0;
    dec_o.kind  = REPLY_NACK;
    dec_o.op    = next_op;
    dec_o.code  = NACK_RECEIVER;
    if (frame_i.frame_ok) begin
      if (frame_i.cmd == CMD_BEACON) begin
        // Request the next operation when a beacon from an allowed sender on this stream announces newer ones.
        dec_o.emit = !sender_bad && !stream_bad && !op_old;
        dec_o.kind = REPLY_REQUEST;
      end else if (sender_bad) begin
        dec_o.emit = 1'b1;
      end else if (frame_i.dest_id != cfg_i.own_id) begin
        dec_o.emit = 1'b0;
      end else if (stream_bad) begin
        dec_o.emit = 1'b1;
        dec_o.code = NACK_STREAM;
      end else if (op_invalid) begin
        dec_o.emit = 1'b1;
        dec_o.code = NACK_INVALID;
      end else if (op_old) begin
        // Duplicate: acknowledge what is already applied.
        dec_o.emit = 1'b1;
        dec_o.kind = REPLY_ACK;
        dec_o.op   = last_applied_i;
      end else if (frame_i.op_number != next_op) begin
        dec_o.emit = 1'b1;
        dec_o.code = NACK_GAP;
      end else if (!frame_i.apply_ok) begin
        dec_o.emit = 1'b1;
        dec_o.code = NACK_APPLY;
      end else begin
        dec_o.emit  = 1'b1;
        dec_o.apply = 1'b1;
        dec_o.kind  = REPLY_ACK;
        dec_o.op    = frame_i.op_number;
      end
    end
    if (dec_o.kind != REPLY_NACK) begin
      dec_o.code = NACK_RECEIVER;
    end
  end

endmodule

// ===== rtl/core/in_order_op_receiver.sv =====
// Top level of the in-order operation receiver with cumulative acknowledgement.
// A taken frame is decided in the input register; a replying frame is then loaded into the
// reply register, which drives the output until the sink takes it.
// Throughput: one frame per cycle; the input register drains into the reply register.
// A frame stalls only while a reply waits in the reply register and the sink is not ready.
// Reset: config registers and last applied op clear to zero, outgoing sequence to one.
`timescale 1ns / 1ps
`include "in_order_op_receiver_macros.svh"

module in_order_op_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ioor_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ioor_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ioor_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  ioor_frame_if.sink                      frame_i,
  ioor_reply_if.source                    reply_o
);
  import ioor_pkg::*;

  // Configuration registers.
  logic [15:0] own_id_q;
  logic [15:0] allowed_sender_q;
  logic [31:0] stream_number_q;
  logic [31:0] start_op_q;
  cfg_reg_e    cfg_sel;
  logic        cfg_wr;

  // Receiver state.
  logic [31:0] last_applied_q, last_applied_d;
  logic [15:0] tx_seq_q, tx_seq_d;

  // Input register.
  logic        in_valid_q, in_valid_d;
  frame_t      in_frame_q;
  frame_t      in_frame;
  logic        in_take;

  // Reply register.
  logic        out_valid_q, out_valid_d;
  reply_t      out_q;
  logic        out_free;
  logic        out_load;

  cfg_t        cfg;
  decision_t   dec;
  logic        in_done;

  // --------------------------------------------------------------------------
  // Configuration port: write on the access phase, read decode is combinational.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_sel)
      REG_OWN_ID:         prdata = {16'd0, own_id_q};
      REG_ALLOWED_SENDER: prdata = {16'd0, allowed_sender_q};
      REG_STREAM_NUMBER:  prdata = stream_number_q;
      REG_START_OP:       prdata = start_op_q;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q         <= '0;
      allowed_sender_q <= '0;
      stream_number_q  <= '0;
      start_op_q       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_OWN_ID:         own_id_q         <= pwdata[15:0];
        REG_ALLOWED_SENDER: allowed_sender_q <= pwdata[15:0];
        REG_STREAM_NUMBER:  stream_number_q  <= pwdata;
        REG_START_OP:       start_op_q       <= pwdata;
        default:            own_id_q         <= own_id_q;
      endcase
    end
  end

  assign cfg.own_id         = own_id_q;
  assign cfg.allowed_sender = allowed_sender_q;
  assign cfg.stream_number  = stream_number_q;

  // --------------------------------------------------------------------------
  // Input register: take a new item while empty or whenever the held one leaves this cycle.
  // --------------------------------------------------------------------------
  assign in_frame.cmd          = frame_i.cmd;
  assign in_frame.frame_ok     = frame_i.frame_ok;
  assign in_frame.src_node     = frame_i.src_node;
  assign in_frame.dest_id      = frame_i.dest_id;
  assign in_frame.frame_stream = frame_i.frame_stream;
  assign in_frame.op_number    = frame_i.op_number;
  assign in_frame.op_kind      = frame_i.op_kind;
  assign in_frame.op_value     = frame_i.op_value;
  assign in_frame.apply_ok     = frame_i.apply_ok;

  ioor_decide u_decide (
    .frame_i        (in_frame_q),
    .cfg_i          (cfg),
    .last_applied_i (last_applied_q),
    .dec_o          (dec)
  );

  // A silent frame always leaves; a replying one needs room in the reply register.
  assign out_free      = !out_valid_q || reply_o.ready;
  assign in_done       = in_valid_q && (!dec.emit || out_free);
  assign frame_i.ready = !in_valid_q || in_done;
  assign in_take       = frame_i.valid && frame_i.ready;
  assign in_valid_d    = in_take || (in_valid_q && !in_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_frame_q <= in_frame;
    end
  end

  // --------------------------------------------------------------------------
  // State update: advance last applied on a clean apply, load it on a start write.
  // --------------------------------------------------------------------------
  assign out_load = in_done && dec.emit;

  always_comb begin
    last_applied_d = last_applied_q;
    if (cfg_wr && (cfg_sel == REG_START_OP)) begin
      last_applied_d = pwdata;
    end else if (in_done && dec.apply) begin
      last_applied_d = in_frame_q.op_number;
    end
  end

  // Every reply takes the current sequence number; wrap at 16 bits.
  assign tx_seq_d = out_load ? tx_seq_q + 16'd1 : tx_seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_applied_q <= '0;
      tx_seq_q       <= TX_SEQ_RESET;
    end else begin
      last_applied_q <= last_applied_d;
      tx_seq_q       <= tx_seq_d;
    end
  end

  // --------------------------------------------------------------------------
  // Reply register: hold until the sink takes it.
  // --------------------------------------------------------------------------
  assign out_valid_d = out_load || (out_valid_q && !reply_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.kind   <= dec.kind;
      out_q.dest   <= in_frame_q.src_node;
      out_q.seq    <= tx_seq_q;
      out_q.stream <= stream_number_q;
      out_q.op     <= dec.op;
      out_q.code   <= dec.code;
    end
  end

  assign reply_o.valid        = out_valid_q;
  assign reply_o.reply_kind   = out_q.kind;
  assign reply_o.reply_dest   = out_q.dest;
  assign reply_o.reply_seq    = out_q.seq;
  assign reply_o.reply_stream = out_q.stream;
  assign reply_o.reply_op     = out_q.op;
  assign reply_o.nack_code    = out_q.code;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  // The counter has moved exactly one past the reply that is held.
  `IOOR_ASSERT(a_seq_after_reply, !out_valid_q || (tx_seq_q == out_q.seq + 16'd1))
  // Outside start writes the last applied op only steps by one.
  `IOOR_ASSERT(a_apply_steps_by_one, cfg_wr || ((last_applied_d - last_applied_q) <= 32'd1))
  // Requests and acks carry no reject code.
  `IOOR_ASSERT(a_nack_code, !out_valid_q || out_q.kind == REPLY_NACK || out_q.code == NACK_RECEIVER)
  // A replying item that leaves the input register shows up at the output.
  `IOOR_ASSERT_NEXT(a_reply_lands, out_load, out_valid_q)

endmodule
